>>> rtl/core/mmcs_pkg.sv
package mmcs_pkg;

  // Pixel and register widths.
  localparam int unsigned PixW     = 8;
  localparam int unsigned NumLanes = 3;
  localparam int unsigned ProdW    = 2 * PixW;
  localparam int unsigned CntW     = $clog2(PixW);

  // Configuration port geometry.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegMaxValue  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegColorMode = 1'd1;

  // Register reset values.
  localparam logic [PixW-1:0] MaxValueReset = 8'd255;

  // Pass codes carried in the mode field.
  localparam logic ModeMeasure = 1'b0;
  localparam logic ModeApply   = 1'b1;

  typedef logic [PixW-1:0] pix_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  // Control from the sequencer to every lane.
  typedef struct packed {
    logic measure;
    logic frame_start;
    logic apply_load;
    logic mul_en;
    logic div_en;
  } lane_ctl_t;

  // What one lane hands to the merging stage.
  typedef struct packed {
    pix_t value;
    logic flat;
  } lane_res_t;

endpackage

>>> rtl/core/mmcs_if.sv
// Pixel request channel.
interface mmcs_pix_if;
  import mmcs_pkg::*;
  logic valid;
  logic ready;
  logic mode;
  logic frame_start;
  pix_t chan_a;
  pix_t chan_b;
  pix_t chan_c;

  modport source (output valid, output mode, output frame_start,
                  output chan_a, output chan_b, output chan_c, input ready);
  modport sink   (input valid, input mode, input frame_start,
                  input chan_a, input chan_b, input chan_c, output ready);
endinterface

// Stretched pixel channel.
interface mmcs_res_if;
  import mmcs_pkg::*;
  logic valid;
  logic ready;
  pix_t out_a;
  pix_t out_b;
  pix_t out_c;
  logic flat_flag;

  modport source (output valid, output out_a, output out_b, output out_c,
                  output flat_flag, input ready);
  modport sink   (input valid, input out_a, input out_b, input out_c,
                  input flat_flag, output ready);
endinterface

// Register write channel.
interface mmcs_cfg_if;
  import mmcs_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/mmcs_lane.sv
module mmcs_lane (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mmcs_pkg::lane_ctl_t   ctl_i,
  input  logic                  used_i,
  input  mmcs_pkg::pix_t        max_value_i,
  input  mmcs_pkg::pix_t        pix_i,
  output mmcs_pkg::lane_res_t   res_o
);
  import mmcs_pkg::*;

  pix_t low_q, low_d;
  pix_t high_q, high_d;
  pix_t lo_base, hi_base;

  // Marks: frame start restores them, then a used lane folds in the pixel.
  always_comb begin
    lo_base = ctl_i.frame_start ? max_value_i : low_q;
    hi_base = ctl_i.frame_start ? '0 : high_q;
    low_d   = low_q;
    high_d  = high_q;
    if (ctl_i.measure) begin
      low_d  = (used_i && (pix_i < lo_base)) ? pix_i : lo_base;
      high_d = (used_i && (pix_i > hi_base)) ? pix_i : hi_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '1;
      high_q <= '0;
    end else begin
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  // Classification of the apply pixel, latched at acceptance.
  logic used_q, flat_q, zero_q, full_q;
  pix_t diff_q, den_q;

  // Divider datapath: partial remainder, dividend bits still to come, quotient.
  pix_t             rem_q, sh_q, quo_q;
  logic [ProdW-1:0] prod;
  logic [PixW:0]    trial;
  logic [PixW:0]    trial_sub;
  logic             ge;

  always_comb begin
    prod      = ProdW'(diff_q) * ProdW'(max_value_i);
    trial     = {rem_q, sh_q[PixW-1]};
    trial_sub = trial - {1'b0, den_q};
    ge        = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.apply_load) begin
      used_q <= used_i;
      flat_q <= (high_q <= low_q);
      zero_q <= (pix_i <= low_q);
      full_q <= (pix_i >= high_q);
      diff_q <= pix_i - low_q;
      den_q  <= high_q - low_q;
    end
    // For a pixel between the marks, the product is below den * 2^PixW, so its upper half is a valid remainder.
    if (ctl_i.mul_en) begin
      rem_q <= prod[ProdW-1:PixW];
      sh_q  <= prod[PixW-1:0];
    end
    if (ctl_i.div_en) begin
      rem_q <= ge ? trial_sub[PixW-1:0] : trial[PixW-1:0];
      sh_q  <= {sh_q[PixW-2:0], 1'b0};
      quo_q <= {quo_q[PixW-2:0], ge};
    end
  end

  // Saturation, a flat channel and an unused lane override the quotient.
  always_comb begin
    res_o.flat  = used_q && flat_q;
    res_o.value = quo_q;
    if (!used_q || flat_q || zero_q) begin
      res_o.value = '0;
    end else if (full_q) begin
      res_o.value = max_value_i;
    end
  end

endmodule

>>> rtl/core/mmcs_merge.sv
module mmcs_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  mmcs_pkg::lane_res_t lane_i [mmcs_pkg::NumLanes],
  output logic                space_o,
  mmcs_res_if.source          res_o
);
  import mmcs_pkg::*;

  logic valid_q;
  pix_t a_q, b_q, c_q;
  logic flat_q;

  assign space_o = !valid_q || res_o.ready;

  // Output register: valid until the downstream side takes the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // The flag is raised when any used lane saw a high mark not above its low mark.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      a_q    <= lane_i[0].value;
      b_q    <= lane_i[1].value;
      c_q    <= lane_i[2].value;
      flat_q <= lane_i[0].flat | lane_i[1].flat | lane_i[2].flat;
    end
  end

  assign res_o.valid     = valid_q;
  assign res_o.out_a     = a_q;
  assign res_o.out_b     = b_q;
  assign res_o.out_c     = c_q;
  assign res_o.flat_flag = flat_q;

endmodule

>>> rtl/core/min_max_contrast_stretch.sv
// Channel   Role   Carries
// pix_i     sink   mode, frame_start, chan_a, chan_b, chan_c
// res_o     source out_a, out_b, out_c, flat_flag
// cfg_i     sink   index (0 max_value, 1 color_mode), data
//
// Measure pixels stream at one per clock while no apply request is in progress.
// An apply request runs through acceptance, a multiply step, 8 divider steps
// (one quotient bit each in every lane), and the load of the output register.
// The next request is accepted once the result sits in the output register.
// Reset sets low marks to all ones, high marks to zero, max_value to 255, greyscale.
// A stalled output holds the sequencer in its final state until the register frees.
module min_max_contrast_stretch (
  input  logic       clk_i,
  input  logic       rst_ni,
  mmcs_pix_if.sink   pix_i,
  mmcs_res_if.source res_o,
  mmcs_cfg_if.sink   cfg_i
);
  import mmcs_pkg::*;

  // Configuration registers.
  pix_t max_value_q;
  logic color_mode_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q  <= MaxValueReset;
      color_mode_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegMaxValue:  max_value_q  <= cfg_i.data[PixW-1:0];
        RegColorMode: color_mode_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;
  logic            space;
  logic            load;
  lane_ctl_t       ctl;

  assign pix_i.ready = (state_q == ST_IDLE);
  assign accept      = pix_i.valid && pix_i.ready;

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    load            = 1'b0;
    ctl.measure     = 1'b0;
    ctl.frame_start = pix_i.frame_start;
    ctl.apply_load  = 1'b0;
    ctl.mul_en      = 1'b0;
    ctl.div_en      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (pix_i.mode == ModeApply) begin
            ctl.apply_load = 1'b1;
            state_d        = ST_MUL;
          end else begin
            ctl.measure = 1'b1;
          end
        end
      end
      ST_MUL: begin
        ctl.mul_en = 1'b1;
        cnt_d      = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        ctl.div_en = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CntW'(PixW - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (space) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // One lane per color channel; lane 0 is always in use.
  pix_t      lane_pix  [NumLanes];
  logic      lane_used [NumLanes];
  lane_res_t lane_res  [NumLanes];

  assign lane_pix[0]  = pix_i.chan_a;
  assign lane_pix[1]  = pix_i.chan_b;
  assign lane_pix[2]  = pix_i.chan_c;
  assign lane_used[0] = 1'b1;
  assign lane_used[1] = color_mode_q;
  assign lane_used[2] = color_mode_q;

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    mmcs_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .used_i      (lane_used[g]),
      .max_value_i (max_value_q),
      .pix_i       (lane_pix[g]),
      .res_o       (lane_res[g])
    );
  end

  mmcs_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .lane_i  (lane_res),
    .space_o (space),
    .res_o   (res_o)
  );

endmodule
